>>> hw/rtl/vsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_pkg: shared types and helpers of the version string parser
// character codes, error codes, parse state and the identifier helpers
// ----------------------------------------------------------------------------
package vsp_pkg;

  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int unsigned NumW   = 32;
  localparam int unsigned CountW = 8;

  typedef enum logic [2:0] {
    PH_START,
    PH_MAJOR,
    PH_MINOR,
    PH_PATCH,
    PH_PRE,
    PH_BUILD
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_EMPTY        = 4'd1,
    ERR_BAD_NUMBER   = 4'd2,
    ERR_LEADING_ZERO = 4'd3,
    ERR_NO_DOT_MAJOR = 4'd4,
    ERR_NO_DOT_MINOR = 4'd5,
    ERR_PRE_CHAR     = 4'd6,
    ERR_PRE_EMPTY    = 4'd7,
    ERR_PATCH_CHAR   = 4'd8,
    ERR_BUILD_EMPTY  = 4'd9,
    ERR_BUILD_CHAR   = 4'd10,
    ERR_IDENT_EMPTY  = 4'd11,
    ERR_IDENT_ZERO   = 4'd12
  } err_e;

  typedef struct packed {
    phase_e              phase;
    logic [NumW-1:0]     acc;
    logic [NumW-1:0]     major;
    logic [NumW-1:0]     minor;
    logic [1:0]          digit_count;
    logic                first_digit_zero;
    logic [1:0]          ident_length;
    logic                ident_all_digits;
    logic [CountW-1:0]   ident_count;
    logic                char_error_flag;
    err_e                ident_error_code;
    err_e                first_error;
    logic                num_overflow;
    logic                build_nonempty;
  } state_t;

  typedef struct packed {
    err_e              error_code;
    logic [NumW-1:0]   major_value;
    logic [NumW-1:0]   minor_value;
    logic [NumW-1:0]   patch_value;
    logic [CountW-1:0] prerelease_count;
    logic              has_build;
  } result_t;

  function automatic state_t state_reset();
    state_t s;
    s = '0;
    s.phase            = PH_START;
    s.ident_all_digits = 1'b1;
    s.ident_error_code = ERR_NONE;
    s.first_error      = ERR_NONE;
    return s;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_digit(c) || (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]}) ||
           c == CH_HYPHEN || c == CH_DOT;
  endfunction

  function automatic state_t clear_number(state_t s);
    state_t r;
    r = s;
    r.acc              = '0;
    r.digit_count      = 2'd0;
    r.first_digit_zero = 1'b0;
    r.num_overflow     = 1'b0;
    return r;
  endfunction

  function automatic err_e number_error(state_t s);
    err_e e;
    e = ERR_NONE;
    if (s.digit_count == 2'd0 || s.num_overflow) begin
      e = ERR_BAD_NUMBER;
    end else if (s.digit_count == 2'd2 && s.first_digit_zero) begin
      e = ERR_LEADING_ZERO;
    end
    return e;
  endfunction

  function automatic state_t close_ident(state_t s, logic check_lz);
    state_t r;
    err_e   e;
    r = s;
    e = ERR_NONE;
    if (s.ident_length == 2'd0) begin
      e = ERR_IDENT_EMPTY;
    end else if (check_lz && s.ident_all_digits && s.ident_length == 2'd2 &&
                 s.first_digit_zero) begin
      e = ERR_IDENT_ZERO;
    end
    if (e != ERR_NONE && s.ident_error_code == ERR_NONE) begin
      r.ident_error_code = e;
    end
    if (check_lz && s.ident_count != {CountW{1'b1}}) begin
      r.ident_count = s.ident_count + CountW'(1);
    end
    r.ident_length     = 2'd0;
    r.ident_all_digits = 1'b1;
    r.first_digit_zero = 1'b0;
    return r;
  endfunction

  function automatic state_t grow_ident(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    if (s.ident_length == 2'd0) begin
      r.first_digit_zero = (c == CH_ZERO);
    end
    if (s.ident_length != 2'd2) begin
      r.ident_length = s.ident_length + 2'd1;
    end
    if (!is_digit(c)) begin
      r.ident_all_digits = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vsp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_step: one character of the parse
// next parse state from the current state and one word, plus the final result
// ----------------------------------------------------------------------------
module vsp_step (
  input  vsp_pkg::state_t  state_i,
  input  logic [7:0]       char_code_i,
  input  logic             is_last_i,
  input  logic             end_only_i,
  output vsp_pkg::state_t  state_o,
  output logic             emit_o,
  output vsp_pkg::result_t result_o
);
  import vsp_pkg::*;

  state_t      s;
  state_t      fs;
  err_e        ne;
  err_e        fe;
  logic        cont;
  logic [35:0] prod;

  // character step
  always_comb begin
    s    = state_i;
    ne   = ERR_NONE;
    cont = 1'b0;
    prod = ({4'd0, state_i.acc} << 3) + ({4'd0, state_i.acc} << 1) +
           {32'd0, char_code_i[3:0]};
    if (!end_only_i && s.first_error == ERR_NONE) begin
      cont = 1'b1;
      if (s.phase == PH_START) begin
        s.phase = PH_MAJOR;
        if (char_code_i == CH_V) begin
          cont = 1'b0;
        end
      end
      if (cont) begin
        case (s.phase)
          PH_MAJOR, PH_MINOR, PH_PATCH: begin
            if (is_digit(char_code_i)) begin
              if (s.digit_count == 2'd0) begin
                s.first_digit_zero = (char_code_i == CH_ZERO);
              end
              if (s.digit_count != 2'd2) begin
                s.digit_count = s.digit_count + 2'd1;
              end
              if (|prod[35:32]) begin
                s.num_overflow = 1'b1;
              end
              s.acc = prod[31:0];
            end else begin
              ne = number_error(s);
              if (ne != ERR_NONE) begin
                s.first_error = ne;
              end else if (s.phase == PH_MAJOR) begin
                if (char_code_i != CH_DOT) begin
                  s.first_error = ERR_NO_DOT_MAJOR;
                end else begin
                  s.major = s.acc;
                  s       = clear_number(s);
                  s.phase = PH_MINOR;
                end
              end else if (s.phase == PH_MINOR) begin
                if (char_code_i != CH_DOT) begin
                  s.first_error = ERR_NO_DOT_MINOR;
                end else begin
                  s.minor = s.acc;
                  s       = clear_number(s);
                  s.phase = PH_PATCH;
                end
              end else if (char_code_i == CH_HYPHEN) begin
                s.phase = PH_PRE;
              end else if (char_code_i == CH_PLUS) begin
                s.phase = PH_BUILD;
              end else begin
                s.first_error = ERR_PATCH_CHAR;
              end
            end
          end
          PH_PRE: begin
            if (is_ident_char(char_code_i)) begin
              if (char_code_i == CH_DOT) begin
                s = close_ident(s, 1'b1);
              end else begin
                s = grow_ident(s, char_code_i);
              end
            end else if (char_code_i != CH_PLUS) begin
              s.first_error = ERR_PRE_CHAR;
            end else if (s.ident_count == '0 && s.ident_length == 2'd0) begin
              s.first_error = ERR_PRE_EMPTY;
            end else begin
              s = close_ident(s, 1'b1);
              if (s.ident_error_code != ERR_NONE) begin
                s.first_error = s.ident_error_code;
              end else begin
                s.phase = PH_BUILD;
              end
            end
          end
          PH_BUILD: begin
            s.build_nonempty = 1'b1;
            if (!is_ident_char(char_code_i)) begin
              s.char_error_flag = 1'b1;
            end else if (char_code_i == CH_DOT) begin
              s = close_ident(s, 1'b0);
            end else begin
              s = grow_ident(s, char_code_i);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // end of string check
  always_comb begin
    fs = s;
    fe = ERR_NONE;
    if (s.first_error != ERR_NONE) begin
      fe = s.first_error;
    end else begin
      case (s.phase)
        PH_START: fe = ERR_EMPTY;
        PH_MAJOR: begin
          fe = number_error(s);
          if (fe == ERR_NONE) fe = ERR_NO_DOT_MAJOR;
        end
        PH_MINOR: begin
          fe = number_error(s);
          if (fe == ERR_NONE) fe = ERR_NO_DOT_MINOR;
        end
        PH_PATCH: fe = number_error(s);
        PH_PRE: begin
          if (s.ident_count == '0 && s.ident_length == 2'd0) begin
            fe = ERR_PRE_EMPTY;
          end else begin
            fs = close_ident(s, 1'b1);
            fe = fs.ident_error_code;
          end
        end
        default: begin
          if (!s.build_nonempty) begin
            fe = ERR_BUILD_EMPTY;
          end else if (s.char_error_flag) begin
            fe = ERR_BUILD_CHAR;
          end else begin
            fs = close_ident(s, 1'b0);
            fe = fs.ident_error_code;
          end
        end
      endcase
    end
  end

  always_comb begin
    emit_o   = end_only_i || is_last_i;
    result_o = '0;
    result_o.error_code = fe;
    if (fe == ERR_NONE) begin
      result_o.major_value = s.major;
      result_o.minor_value = s.minor;
      result_o.patch_value = s.acc;
      if (s.phase == PH_PRE || s.phase == PH_BUILD) begin
        result_o.prerelease_count = fs.ident_count;
      end
      result_o.has_build = (s.phase == PH_BUILD);
    end
    state_o = emit_o ? state_reset() : s;
  end

endmodule
`default_nettype wire

>>> hw/rtl/version_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// version_string_parser: streaming semantic version checker
// validates a version string one character per word and reports the numbers
// ----------------------------------------------------------------------------
// The block takes one character word per clock unless an ending word waits in
// the input register for the result slot. A word sits in the input register
// while the step logic updates the parse state; the result, produced only for
// the word that ends the string (is_last or end_only), is written to the result
// register when that word moves on and is offered from there. The longest path
// is the accumulator's multiply-by-ten-and-add with its overflow test. The
// result register frees the input side: new words keep flowing while a
// finished result waits, and only a second ending word stalls until the first
// result is taken. After each result the parser is back at the start of a
// string, ready for the next one.
// ----------------------------------------------------------------------------
module version_string_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_i,
  input  logic        end_only_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  error_code_o,
  output logic [31:0] major_value_o,
  output logic [31:0] minor_value_o,
  output logic [31:0] patch_value_o,
  output logic [7:0]  prerelease_count_o,
  output logic        has_build_o
);
  import vsp_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       end_only_q;

  // parse state and result register
  state_t  state_q;
  state_t  state_d;
  logic    emit;
  logic    advance;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;

  vsp_step u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .is_last_i   (last_q),
    .end_only_i  (end_only_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (res_d)
  );

  // a held word moves on unless it ends a string and the result slot is full
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q     <= char_code_i;
      last_q     <= is_last_i;
      end_only_q <= end_only_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= state_reset();
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign error_code_o       = res_q.error_code;
  assign major_value_o      = res_q.major_value;
  assign minor_value_o      = res_q.minor_value;
  assign patch_value_o      = res_q.patch_value;
  assign prerelease_count_o = res_q.prerelease_count;
  assign has_build_o        = res_q.has_build;

  // a failed parse reports nothing but its code
  a_err_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.error_code != ERR_NONE |->
      res_q.major_value == '0 && res_q.minor_value == '0 &&
      res_q.patch_value == '0 && res_q.prerelease_count == '0 && !res_q.has_build)
    else $error("error result carries non-zero fields");

  // the parser restarts after every result
  a_restart_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> state_q.phase == PH_START && state_q.first_error == ERR_NONE)
    else $error("parse state not cleared after result");

  // the first character always leaves the start phase
  a_no_error_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.first_error != ERR_NONE |-> state_q.phase != PH_START)
    else $error("error recorded before any character");

  // a stalled word is held until it moves on
  a_stall_holds_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(char_q) && $stable(state_q))
    else $error("stalled word lost or state moved");

endmodule
`default_nettype wire

>>> tb/sv/version_string_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_parser_test: self-checking bench for the version parser
// drives version strings one character word at a time, mirrors the parse in
// a behavioural tracker and checks every result word against it, under
// several sender and receiver idling mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module version_string_parser_test;
  import vsp_pkg::*;

  // expected contents of one result word
  typedef struct packed {
    err_e        code;
    logic [31:0] major_v;
    logic [31:0] minor_v;
    logic [31:0] patch_v;
    logic [7:0]  pre_count;
    logic        build_flag;
  } verdict_t;

  // one directed string; want fields are used only when typed is set
  typedef struct {
    string       text;
    bit          via_end;
    bit          typed;
    err_e        want_code;
    logic [31:0] want_major;
  } plan_row_t;

  localparam int PlanRows   = 25;
  localparam int HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        is_last_i;
  logic        end_only_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  error_code_o;
  logic [31:0] major_value_o;
  logic [31:0] minor_value_o;
  logic [31:0] patch_value_o;
  logic [7:0]  prerelease_count_o;
  logic        has_build_o;

  // results still owed by the block, oldest first
  verdict_t    pending_verdicts[$];
  // characters of the string being sent
  logic [7:0]  draft[$];
  int          mismatches     = 0;
  int          words_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  string       ident_alphabet = "0123456789abcxyzABCXYZ-";

  // tracker copy of the parse state
  phase_e      scan_ph;
  logic [31:0] num_acc;
  logic [31:0] major_q;
  logic [31:0] minor_q;
  logic [1:0]  ndigits;
  logic        lead_zero;
  logic        num_ovf;
  logic [1:0]  id_len;
  logic        id_numeric;
  logic [7:0]  id_total;
  logic        build_bad_char;
  logic        build_seen;
  err_e        id_err;
  err_e        first_err;

  // directed strings: every error code, number extremes and precedence cases
  plan_row_t directed_plan [PlanRows] = '{
    '{"",                        1'b1, 1'b1, ERR_EMPTY,        32'd0},
    '{"v",                       1'b0, 1'b1, ERR_BAD_NUMBER,   32'd0},
    '{"4294967295.0.0",          1'b0, 1'b1, ERR_NONE,         32'hFFFF_FFFF},
    '{"4294967296.0.0",          1'b0, 1'b1, ERR_BAD_NUMBER,   32'd0},
    '{"01.2.3",                  1'b0, 1'b1, ERR_LEADING_ZERO, 32'd0},
    '{"1x",                      1'b0, 1'b1, ERR_NO_DOT_MAJOR, 32'd0},
    '{"1.2",                     1'b1, 1'b1, ERR_NO_DOT_MINOR, 32'd0},
    '{"1.2.3-a$",                1'b0, 1'b1, ERR_PRE_CHAR,     32'd0},
    '{"1.2.3-+",                 1'b0, 1'b1, ERR_PRE_EMPTY,    32'd0},
    '{"1.2.3x",                  1'b0, 1'b1, ERR_PATCH_CHAR,   32'd0},
    '{"1.2.3+",                  1'b0, 1'b1, ERR_BUILD_EMPTY,  32'd0},
    '{"1.2.3+a$..",              1'b0, 1'b1, ERR_BUILD_CHAR,   32'd0},
    '{"1.2.3-a..b",              1'b0, 1'b1, ERR_IDENT_EMPTY,  32'd0},
    '{"1.2.3-01",                1'b0, 1'b1, ERR_IDENT_ZERO,   32'd0},
    '{"1.2.3-a$x",               1'b1, 1'b1, ERR_PRE_CHAR,     32'd0},
    '{"v1.2.3-rc.1+b.7",         1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"0.4294967295.4294967295", 1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3-0a.00x+\377",       1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3-0.-.x-y",           1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3-a+",                1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3+.a",                1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.-2.3",                  1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3-00+x",              1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.3+01.x-Y",            1'b0, 1'b0, ERR_NONE,         32'd0},
    '{"1.2.01",                  1'b1, 1'b0, ERR_NONE,         32'd0}
  };

  version_string_parser DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .char_code_i        (char_code_i),
    .is_last_i          (is_last_i),
    .end_only_i         (end_only_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .error_code_o       (error_code_o),
    .major_value_o      (major_value_o),
    .minor_value_o      (minor_value_o),
    .patch_value_o      (patch_value_o),
    .prerelease_count_o (prerelease_count_o),
    .has_build_o        (has_build_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parse tracker
  // ---------------------------------------------------------------------------

  function automatic bit dec_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit ident_char(logic [7:0] c);
    return dec_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CH_HYPHEN || c == CH_DOT;
  endfunction

  function automatic void wipe_number();
    num_acc   = '0;
    ndigits   = '0;
    lead_zero = 1'b0;
    num_ovf   = 1'b0;
  endfunction

  function automatic void restart_scan();
    scan_ph = PH_START;
    wipe_number();
    major_q        = '0;
    minor_q        = '0;
    id_len         = '0;
    id_numeric     = 1'b1;
    id_total       = '0;
    build_bad_char = 1'b0;
    build_seen     = 1'b0;
    id_err         = ERR_NONE;
    first_err      = ERR_NONE;
  endfunction

  // accumulate one decimal digit, flagging anything past 32 bits
  function automatic void take_digit(logic [7:0] c);
    logic [35:0] wide;
    logic [3:0]  d;
    d    = 4'(c - CH_ZERO);
    wide = 36'(num_acc) * 36'd10 + 36'(d);
    if (ndigits == 2'd0) lead_zero = (d == 4'd0);
    if (ndigits != 2'd2) ndigits = ndigits + 2'd1;
    if (wide[35:32] != 4'd0) num_ovf = 1'b1;
    num_acc = wide[31:0];
  endfunction

  function automatic err_e num_check();
    err_e e;
    e = ERR_NONE;
    if (ndigits == 2'd0 || num_ovf) e = ERR_BAD_NUMBER;
    else if (ndigits == 2'd2 && lead_zero) e = ERR_LEADING_ZERO;
    return e;
  endfunction

  // close an identifier; only prerelease ones are counted and zero-checked
  function automatic void end_ident(bit pre);
    err_e e;
    e = ERR_NONE;
    if (id_len == 2'd0) e = ERR_IDENT_EMPTY;
    else if (pre && id_numeric && id_len == 2'd2 && lead_zero) e = ERR_IDENT_ZERO;
    if (e != ERR_NONE && id_err == ERR_NONE) id_err = e;
    if (pre && id_total != 8'hFF) id_total = id_total + 8'd1;
    id_len     = '0;
    id_numeric = 1'b1;
    lead_zero  = 1'b0;
  endfunction

  function automatic void extend_ident(logic [7:0] c);
    if (id_len == 2'd0) lead_zero = (c == CH_ZERO);
    if (id_len != 2'd2) id_len = id_len + 2'd1;
    if (!dec_digit(c)) id_numeric = 1'b0;
  endfunction

  function automatic void flag_error(err_e e);
    if (first_err == ERR_NONE) first_err = e;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    err_e e;
    // after the first error the rest of the string is ignored
    if (first_err != ERR_NONE) return;
    if (scan_ph == PH_START) begin
      scan_ph = PH_MAJOR;
      if (c == CH_V) return;
    end
    if (scan_ph inside {PH_MAJOR, PH_MINOR, PH_PATCH}) begin
      if (dec_digit(c)) begin
        take_digit(c);
        return;
      end
      e = num_check();
      if (e != ERR_NONE) begin
        flag_error(e);
        return;
      end
      case (scan_ph)
        PH_MAJOR: begin
          if (c != CH_DOT) begin
            flag_error(ERR_NO_DOT_MAJOR);
          end else begin
            major_q = num_acc;
            wipe_number();
            scan_ph = PH_MINOR;
          end
        end
        PH_MINOR: begin
          if (c != CH_DOT) begin
            flag_error(ERR_NO_DOT_MINOR);
          end else begin
            minor_q = num_acc;
            wipe_number();
            scan_ph = PH_PATCH;
          end
        end
        default: begin
          if (c == CH_HYPHEN) scan_ph = PH_PRE;
          else if (c == CH_PLUS) scan_ph = PH_BUILD;
          else flag_error(ERR_PATCH_CHAR);
        end
      endcase
      return;
    end
    if (scan_ph == PH_PRE) begin
      if (ident_char(c)) begin
        if (c == CH_DOT) end_ident(1'b1);
        else extend_ident(c);
      end else if (c != CH_PLUS) begin
        flag_error(ERR_PRE_CHAR);
      end else if (id_total == 8'd0 && id_len == 2'd0) begin
        flag_error(ERR_PRE_EMPTY);
      end else begin
        end_ident(1'b1);
        if (id_err != ERR_NONE) flag_error(id_err);
        else scan_ph = PH_BUILD;
      end
      return;
    end
    // build metadata: a bad character only shows at the end of the string
    build_seen = 1'b1;
    if (!ident_char(c)) build_bad_char = 1'b1;
    else if (c == CH_DOT) end_ident(1'b0);
    else extend_ident(c);
  endfunction

  // error code at the end of the string, in the block's order of checks
  function automatic err_e end_code();
    err_e e;
    e = first_err;
    if (e == ERR_NONE) begin
      case (scan_ph)
        PH_START: e = ERR_EMPTY;
        PH_MAJOR: begin
          e = num_check();
          if (e == ERR_NONE) e = ERR_NO_DOT_MAJOR;
        end
        PH_MINOR: begin
          e = num_check();
          if (e == ERR_NONE) e = ERR_NO_DOT_MINOR;
        end
        PH_PATCH: e = num_check();
        PH_PRE: begin
          if (id_total == 8'd0 && id_len == 2'd0) begin
            e = ERR_PRE_EMPTY;
          end else begin
            end_ident(1'b1);
            e = id_err;
          end
        end
        default: begin
          if (!build_seen) begin
            e = ERR_BUILD_EMPTY;
          end else if (build_bad_char) begin
            e = ERR_BUILD_CHAR;
          end else begin
            end_ident(1'b0);
            e = id_err;
          end
        end
      endcase
    end
    return e;
  endfunction

  // feed one accepted word; returns 1 with the result when it ends a string
  function automatic bit absorb_word(logic [7:0] c, logic last, logic endo,
                                     output verdict_t v);
    v = '0;
    if (!endo) scan_char(c);
    if (!endo && !last) return 1'b0;
    v.code = end_code();
    // an error result carries nothing but its code
    if (v.code == ERR_NONE) begin
      v.major_v    = major_q;
      v.minor_v    = minor_q;
      v.patch_v    = num_acc;
      v.pre_count  = (scan_ph == PH_PRE || scan_ph == PH_BUILD) ? id_total : 8'd0;
      v.build_flag = (scan_ph == PH_BUILD);
    end
    restart_scan();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // string generation
  // ---------------------------------------------------------------------------

  // append one character to the string being built
  function automatic void add_char(logic [7:0] c);
    draft.insert(draft.size(), c);
  endfunction

  // queue a result the block now owes
  function automatic void owe_verdict(verdict_t v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // mostly small numbers, with empties, leading zeros, the maximum and overflow
  function automatic void append_number(bit tidy);
    string       txt;
    int unsigned pick;
    pick = tidy ? 99 : $urandom_range(99);
    if (pick < 5) txt = "";
    else if (pick < 10) txt = "4294967295";
    else if (pick < 15) txt = $sformatf("%0d", 64'd4294967296 + 64'($urandom()));
    else if (pick < 21) txt = $sformatf("0%0d", $urandom_range(99));
    else if (pick < 30) txt = $sformatf("%0d", $urandom());
    else if (pick < 40) txt = "0";
    else txt = $sformatf("%0d", $urandom_range(999));
    for (int i = 0; i < txt.len(); i++) add_char(txt[i]);
  endfunction

  function automatic void append_sep(bit tidy);
    if (!tidy && $urandom_range(99) < 4) add_char(8'($urandom_range(255)));
    else add_char(CH_DOT);
  endfunction

  // identifier: sometimes empty, sometimes numeric with a leading zero
  function automatic void append_ident(bit tidy);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    len  = $urandom_range(1, 3);
    if (tidy) begin
      add_char(8'("a" + $urandom_range(25)));
      return;
    end
    if (pick < 5) return;
    if (pick < 15) begin
      add_char(CH_ZERO);
      repeat (len) add_char(8'(CH_ZERO + $urandom_range(9)));
      return;
    end
    repeat (len)
      add_char(ident_alphabet[$urandom_range(ident_alphabet.len() - 1)]);
  endfunction

  // mostly well-formed versions with random content, then some damage
  function automatic void compose_version(int unsigned forced_ids);
    bit          tidy;
    int unsigned n_ids;
    tidy = (forced_ids != 0);
    draft.delete();
    if (!tidy && $urandom_range(99) < 3) return;
    if ($urandom_range(99) < 25) add_char(CH_V);
    append_number(tidy);
    append_sep(tidy);
    append_number(tidy);
    append_sep(tidy);
    append_number(tidy);
    if (tidy || $urandom_range(99) < 45) begin
      add_char(CH_HYPHEN);
      n_ids = tidy ? forced_ids : $urandom_range(1, 4);
      for (int k = 0; k < n_ids; k++) begin
        if (k != 0) add_char(CH_DOT);
        append_ident(tidy);
      end
    end
    if ($urandom_range(99) < 35) begin
      add_char(CH_PLUS);
      n_ids = tidy ? 1 : $urandom_range(1, 3);
      for (int k = 0; k < n_ids; k++) begin
        if (k != 0) add_char(CH_DOT);
        append_ident(tidy);
      end
    end
    if (tidy) return;
    // stray byte anywhere in the string
    if (draft.size() != 0 && $urandom_range(99) < 12)
      draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
    // cut short
    if (draft.size() > 1 && $urandom_range(99) < 5)
      repeat ($urandom_range(1, draft.size() - 1)) void'(draft.pop_back());
  endfunction

  // ---------------------------------------------------------------------------
  // sending side
  // ---------------------------------------------------------------------------

  // offer one word, wait for the handshake, then maybe go idle for a while
  task automatic send_word(logic [7:0] c, logic last, logic endo, bit typed,
                           verdict_t typed_v);
    verdict_t v;
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_last_i   <= last;
    end_only_i  <= endo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (absorb_word(c, last, endo, v))
      owe_verdict(typed ? typed_v : v);
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // send draft, closed either by is_last on its last character or by an
  // end-only word whose character and is_last are don't-care
  task automatic send_string(bit via_end, bit typed, verdict_t typed_v);
    for (int i = 0; i < draft.size(); i++)
      send_word(draft[i], !via_end && i == draft.size() - 1, 1'b0, typed, typed_v);
    if (via_end || draft.size() == 0)
      send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, typed, typed_v);
  endtask

  // stop offering and let every owed result drain out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiving side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each result word against the oldest owed result
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result word with none owed: code %0d major %0d",
                   $time, error_code_o, major_value_o);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (error_code_o !== want.code || major_value_o !== want.major_v ||
            minor_value_o !== want.minor_v || patch_value_o !== want.patch_v ||
            prerelease_count_o !== want.pre_count || has_build_o !== want.build_flag) begin
          if (mismatches < 10)
            $display({"%0t: mismatch (exp/got) code %0d/%0d major %0d/%0d minor %0d/%0d",
                      " patch %0d/%0d pre %0d/%0d build %0b/%0b"}, $time,
                     want.code, error_code_o, want.major_v, major_value_o,
                     want.minor_v, minor_value_o, want.patch_v, patch_value_o,
                     want.pre_count, prerelease_count_o, want.build_flag, has_build_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   row;
    verdict_t    typed_v;
    int          target;
    int unsigned idle_mix [4];
    int unsigned stall_mix[4];
    idle_mix  = '{0, 57, 0, 32};
    stall_mix = '{0, 0, 57, 32};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = 8'd0;
    is_last_i   = 1'b0;
    end_only_i  = 1'b0;
    restart_scan();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed strings, no idling
    foreach (directed_plan[r]) begin
      row = directed_plan[r];
      draft.delete();
      for (int i = 0; i < row.text.len(); i++) add_char(row.text[i]);
      typed_v = '{row.want_code, row.want_major, 32'd0, 32'd0, 8'd0, 1'b0};
      send_string(row.via_end, row.typed, typed_v);
    end
    quiesce();

    // random strings under each idling mix, draining between mixes
    for (int mix = 0; mix < 4; mix++) begin
      send_idle_pct  = idle_mix[mix];
      recv_stall_pct = stall_mix[mix];
      target         = words_sent + 220;
      // one long prerelease so the identifier count saturates
      if (mix == 0) begin
        compose_version(300);
        send_string(1'b0, 1'b0, '0);
      end
      while (words_sent < target) begin
        compose_version(0);
        send_string($urandom_range(99) < 15, 1'b0, '0);
      end
      quiesce();
    end

    // receiver holds off while strings keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (20) begin
      compose_version(0);
      send_string($urandom_range(99) < 15, 1'b0, '0);
    end
    quiesce();

    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
